FILE: rtl/fpr_pkg.sv
// fpr_pkg: shared types and constants for the FIFO page replacement block.
// No dependencies; imported by fifo_page_replacement.
package fpr_pkg;

    localparam int ADDR_W     = 32;
    localparam int PSIZE_W    = 17;
    localparam int FCOUNT_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int DCNT_W     = 5;

    localparam logic [CFG_IDX_W-1:0] REG_PSIZE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd1;

    localparam logic [PSIZE_W-1:0]  PSIZE_RESET       = 17'd4096;
    localparam logic [FCOUNT_W-1:0] FRAME_COUNT_RESET = 7'd64;
    localparam logic [ADDR_W-1:0]   FAULT_MAX         = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

FILE: rtl/fifo_page_replacement.sv
// fifo_page_replacement: FIFO page replacement over a stream of byte addresses.
// Depends on fpr_pkg (types, register indexes, reset values).

// One request in, one result out. Each address is divided by the page size in a
// radix-2 restoring divider (one quotient bit per cycle), then the resident
// frames are scanned through the one read port of the frame memory with a
// registered read, one entry per cycle from the oldest slot, until a hit or
// until as many entries as are resident have been read. Only one request is
// in work at a time, but the result sits in an output register, so the next
// request is taken while the previous result waits for m_ready. On a miss the
// fault count (saturating at all ones) is bumped, the oldest frame is dropped
// if the FIFO is full and the new page is written at the write slot. A
// page size of 0 acts as 1; a frame_count of 0 acts as 1 and values above
// MAX_FRAMES act as MAX_FRAMES. Any write to frame_count empties the FIFO
// but keeps the fault count. The user must write configuration only while
// idle; the block itself does not enforce this. Writes to unknown indexes are
// ignored. The frame memory needs no clearing: only slots written since the
// last FIFO reset are ever scanned.
module fifo_page_replacement
    import fpr_pkg::*;
#(
    parameter int MAX_FRAMES = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ADDR_W-1:0]     s_address,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ADDR_W-1:0]     m_page_number,
    output logic                  m_fault,
    output logic [ADDR_W-1:0]     m_fault_total
);

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(ADDR_W - 1);

    // ---------------- configuration ----------------
    logic [PSIZE_W-1:0]  psize_reg, psize_next;
    logic [FCOUNT_W-1:0] frame_count_reg, frame_count_next;

    // ---------------- control / datapath registers ----------------
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   quo_reg, quo_next;       // dividend in, quotient out
    logic [PSIZE_W-1:0]  rem_reg, rem_next;
    logic [DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;      // next slot to read
    logic [CNT_W-1:0]    issue_reg, issue_next;    // reads issued so far
    logic                cmp_vld_reg, cmp_vld_next;
    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    oldest_reg, oldest_next;
    logic [IDX_W-1:0]    wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic [ADDR_W-1:0]   faults_reg, faults_next;

    logic                m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]   m_page_reg, m_page_next;
    logic                m_fault_reg, m_fault_next;
    logic [ADDR_W-1:0]   m_total_reg, m_total_next;

    // ---------------- frame memory ----------------
    logic [ADDR_W-1:0]   frame_mem [MAX_FRAMES];
    logic [ADDR_W-1:0]   rd_data_reg;

    // control strobes
    logic                accept;
    logic                rd_en;
    logic                done_fire;
    logic                wr_en;

    // derived values
    logic [31:0]         fc_ext;
    logic [31:0]         cap_ext;
    logic [CNT_W-1:0]    cap;
    logic [CNT_W-1:0]    scan_limit;
    logic [PSIZE_W-1:0]  divisor;
    logic [PSIZE_W:0]    trial;
    logic                trial_ge;
    logic                hit_now;
    logic                scan_end;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot,
                                                  input logic [CNT_W-1:0] limit);
        logic [CNT_W-1:0] n;
        n = CNT_W'(slot) + 1'b1;
        return (n >= limit) ? '0 : IDX_W'(n);
    endfunction

    // Effective frame count: 0 acts as 1, clip at MAX_FRAMES.
    assign fc_ext  = 32'(frame_count_reg);
    assign cap_ext = (frame_count_reg == '0) ? 32'd1 :
                     ((fc_ext > 32'(MAX_FRAMES)) ? 32'(MAX_FRAMES) : fc_ext);
    assign cap     = cap_ext[CNT_W-1:0];
    assign scan_limit = (occ_reg < cap) ? occ_reg : cap;

    assign divisor  = (psize_reg == '0) ? PSIZE_W'(1) : psize_reg;
    assign trial    = {rem_reg, quo_reg[ADDR_W-1]};
    assign trial_ge = (trial >= {1'b0, divisor});

    // Compare the entry read last cycle against the page under test.
    assign hit_now  = cmp_vld_reg && (rd_data_reg == quo_reg);
    assign scan_end = hit_now || (issue_reg >= scan_limit);

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (dcnt_reg == DIV_LAST) state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_end) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        s_ready   = 1'b0;
        rd_en     = 1'b0;
        done_fire = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_SCAN: rd_en   = !scan_end;
            ST_DONE: done_fire = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    assign accept = s_valid && s_ready;
    assign wr_en  = done_fire && !hit_reg;

    // ---------------- datapath ----------------
    always_comb begin
        psize_next       = psize_reg;
        frame_count_next = frame_count_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        dcnt_next        = dcnt_reg;
        slot_next        = slot_reg;
        issue_next       = issue_reg;
        cmp_vld_next     = cmp_vld_reg;
        hit_next         = hit_reg;
        oldest_next      = oldest_reg;
        wr_idx_next      = wr_idx_reg;
        occ_next         = occ_reg;
        faults_next      = faults_reg;
        m_valid_next     = m_valid_reg;
        m_page_next      = m_page_reg;
        m_fault_next     = m_fault_reg;
        m_total_next     = m_total_reg;

        if (m_ready) m_valid_next = 1'b0;

        if (accept) begin
            quo_next  = s_address;
            rem_next  = '0;
            dcnt_next = '0;
        end

        // restoring divide, one quotient bit per cycle
        if (state_reg == ST_DIV) begin
            rem_next  = trial_ge ? PSIZE_W'(trial - {1'b0, divisor}) : trial[PSIZE_W-1:0];
            quo_next  = {quo_reg[ADDR_W-2:0], trial_ge};
            dcnt_next = dcnt_reg + 1'b1;
            if (dcnt_reg == DIV_LAST) begin
                slot_next    = oldest_reg;
                issue_next   = '0;
                cmp_vld_next = 1'b0;
            end
        end

        if (state_reg == ST_SCAN) begin
            cmp_vld_next = rd_en;
            if (rd_en) begin
                slot_next  = next_slot(slot_reg, cap);
                issue_next = issue_reg + 1'b1;
            end
            hit_next = hit_now;
        end

        if (done_fire) begin
            m_valid_next = 1'b1;
            m_page_next  = quo_reg;
            m_fault_next = !hit_reg;
            m_total_next = faults_reg;
            if (!hit_reg) begin
                if (faults_reg != FAULT_MAX) begin
                    faults_next  = faults_reg + 1'b1;
                    m_total_next = faults_reg + 1'b1;
                end
                if (occ_reg >= cap) begin
                    oldest_next = next_slot(oldest_reg, cap);
                    occ_next    = cap;
                end else begin
                    occ_next    = occ_reg + 1'b1;
                end
                wr_idx_next = next_slot(wr_idx_reg, cap);
            end
        end

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_PSIZE: psize_next = cfg_wdata[PSIZE_W-1:0];
                REG_FRAME_COUNT: begin
                    frame_count_next = cfg_wdata[FCOUNT_W-1:0];
                    oldest_next      = '0;
                    wr_idx_next      = '0;
                    occ_next         = '0;
                end
                default: ;
            endcase
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            psize_reg       <= PSIZE_RESET;
            frame_count_reg <= FRAME_COUNT_RESET;
            oldest_reg      <= '0;
            wr_idx_reg      <= '0;
            occ_reg         <= '0;
            faults_reg      <= '0;
            m_valid_reg     <= 1'b0;
            cmp_vld_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            psize_reg       <= psize_next;
            frame_count_reg <= frame_count_next;
            oldest_reg      <= oldest_next;
            wr_idx_reg      <= wr_idx_next;
            occ_reg         <= occ_next;
            faults_reg      <= faults_next;
            m_valid_reg     <= m_valid_next;
            cmp_vld_reg     <= cmp_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        dcnt_reg    <= dcnt_next;
        slot_reg    <= slot_next;
        issue_reg   <= issue_next;
        hit_reg     <= hit_next;
        m_page_reg  <= m_page_next;
        m_fault_reg <= m_fault_next;
        m_total_reg <= m_total_next;
    end

    // Frame memory: one read port (scan), one write port (miss fill).
    // The scan finishes before the fill, so the two never hit one entry
    // in the same request.
    always_ff @(posedge aclk) begin
        if (rd_en) rd_data_reg <= frame_mem[slot_reg];
    end

    always_ff @(posedge aclk) begin
        if (wr_en) frame_mem[wr_idx_reg] <= quo_reg;
    end

    assign m_valid       = m_valid_reg;
    assign m_page_number = m_page_reg;
    assign m_fault       = m_fault_reg;
    assign m_fault_total = m_total_reg;

endmodule
